// ----- sv/tfh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfh_pkg
// Shared types, widths and codes of the triangle face hash table.
// ----------------------------------------------------------------------------
package tfh_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int LIMIT_BITS  = ADDR_BITS + 1;
    localparam int VERTEX_BITS = 24;
    localparam int SUM_BITS    = VERTEX_BITS + 2;
    localparam int KEY_BITS    = VERTEX_BITS + 5;
    localparam int ID_BITS     = 30;
    localparam int KIND_BITS   = 2;
    localparam int STATUS_BITS = 3;
    localparam int BKT_BITS    = 12;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 13;

    localparam int KEY_MUL_MIN = 7;
    localparam int KEY_MUL_MAX = 11;

    localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_NEW     = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_FOUND   = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_MISS    = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_CLEARED = 3'd4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BUCKET_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TABLE_LIMIT  = 2'd1;

    localparam logic [BKT_BITS-1:0]   BUCKET_RESET = 12'd1024;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET  = LIMIT_BITS'(TABLE_DEPTH);

    typedef struct packed {
        logic [VERTEX_BITS-1:0] min_vertex;
        logic [VERTEX_BITS-1:0] max_vertex;
        logic [SUM_BITS-1:0]    vertex_sum;
        logic [ID_BITS-1:0]     id;
        logic [ADDR_BITS-1:0]   link;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_MOD,
        S_RD,
        S_CHK,
        S_NEW,
        S_DONE
    } state_t;

endpackage

// ----- sv/tfh_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfh_if
// Request, result and register write channels of the triangle hash table.
// ----------------------------------------------------------------------------
interface tfh_req_if
    import tfh_pkg::*;
    ();
    logic                   valid;
    logic                   ready;
    logic [KIND_BITS-1:0]   kind;
    logic [VERTEX_BITS-1:0] vertex_a;
    logic [VERTEX_BITS-1:0] vertex_b;
    logic [VERTEX_BITS-1:0] vertex_c;
    logic [ID_BITS-1:0]     face_id;

    modport source (output valid, kind, vertex_a, vertex_b, vertex_c, face_id,
                    input ready);
    modport sink   (input valid, kind, vertex_a, vertex_b, vertex_c, face_id,
                    output ready);
endinterface

interface tfh_res_if
    import tfh_pkg::*;
    ();
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [ID_BITS-1:0]     match_id;

    modport source (output valid, status, match_id, input ready);
    modport sink   (input valid, status, match_id, output ready);
endinterface

interface tfh_cfg_if
    import tfh_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/tfh_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfh_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module tfh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- sv/tfh_mod.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfh_mod
// Restoring remainder unit: one dividend bit per cycle, one shared subtractor.
// ----------------------------------------------------------------------------
module tfh_mod
    import tfh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [KEY_BITS-1:0]   dividend,
    input  logic [LIMIT_BITS-1:0] divisor,
    output logic                  done,
    output logic [ADDR_BITS-1:0]  remainder
);

    localparam int CNT_BITS = $clog2(KEY_BITS + 1);

    logic [LIMIT_BITS-1:0] rem_reg;
    logic [KEY_BITS-1:0]   dvd_reg;
    logic [LIMIT_BITS-1:0] div_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [LIMIT_BITS:0]   trial;
    logic [LIMIT_BITS:0]   diff;

    assign trial = {rem_reg, dvd_reg[KEY_BITS-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(KEY_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[KEY_BITS-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_reg <= diff[LIMIT_BITS-1:0];
            end
            else
            begin
                rem_reg <= trial[LIMIT_BITS-1:0];
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[ADDR_BITS-1:0];

endmodule

// ----- sv/triangle_face_hash_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_hash_table
// Chained hash table of triangles with an in-order overflow area.
// ----------------------------------------------------------------------------
// One request at a time. An insert or lookup first runs the bit-serial remainder
// unit for the bucket key (29 steps, then a done pulse), then a registered RAM
// read and a compare for each chain entry visited, a store of a chained entry
// where one is added, and the hand-over of the result. Kind 3 and zero-vertex
// requests skip the remainder unit and the table and go straight to the result.
// A clear request, a write to either register and reset run a clearing pass over
// all 4096 entries of the entry RAM, one entry a cycle; requests wait meanwhile,
// register writes are always taken and a write to either register restarts the pass.
// ----------------------------------------------------------------------------
module triangle_face_hash_table
    import tfh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tfh_req_if.sink    in_ch,
    tfh_res_if.source  out_ch,
    tfh_cfg_if.sink    cfg
);

    state_t                 state_reg, state_next;
    logic [KIND_BITS-1:0]   kind_reg;
    logic [VERTEX_BITS-1:0] mn_reg, mx_reg;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [ID_BITS-1:0]     id_reg;
    logic [ADDR_BITS-1:0]   cur_reg;
    logic                   first_reg;
    logic [LIMIT_BITS-1:0]  nf_reg;
    logic [ADDR_BITS-1:0]   clr_reg;
    logic                   pend_reg;
    logic [STATUS_BITS-1:0] res_status_reg;
    logic [ID_BITS-1:0]     res_id_reg;
    logic                   out_valid_reg;
    logic [STATUS_BITS-1:0] out_status_reg;
    logic [ID_BITS-1:0]     out_id_reg;
    logic [BKT_BITS-1:0]    bucket_reg;
    logic [LIMIT_BITS-1:0]  limit_reg;

    logic                   req_fire, cfg_fire, cfg_clr, out_free;
    logic [VERTEX_BITS-1:0] in_mn, in_mx, ab_mn, ab_mx;
    logic [KEY_BITS-1:0]    key_raw;
    logic [LIMIT_BITS-1:0]  lim_eff, bkt_eff;
    logic                   req_go;
    logic                   mod_start, mod_done;
    logic [ADDR_BITS-1:0]   mod_rem;

    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_addr;
    entry_t                 ram_wdata, rd;
    logic [ENTRY_BITS-1:0]  ram_rdata;
    entry_t                 new_entry;
    logic                   hit, empty, more, room, store_home, store_chain;

    // effective sizes
    always_comb
    begin
        if (limit_reg == '0)
            lim_eff = LIMIT_BITS'(1);
        else if (limit_reg > LIMIT_BITS'(TABLE_DEPTH))
            lim_eff = LIMIT_BITS'(TABLE_DEPTH);
        else
            lim_eff = limit_reg;
        if (bucket_reg == '0)
            bkt_eff = LIMIT_BITS'(1);
        else if ({1'b0, bucket_reg} > lim_eff)
            bkt_eff = lim_eff;
        else
            bkt_eff = {1'b0, bucket_reg};
    end

    assign req_fire = in_ch.valid && in_ch.ready;
    assign cfg_fire = cfg.valid && cfg.ready;
    assign cfg_clr  = cfg_fire && (cfg.index == CFG_BUCKET_COUNT
                                   || cfg.index == CFG_TABLE_LIMIT);
    assign out_free = !out_valid_reg || out_ch.ready;

    assign ab_mn = (in_ch.vertex_a < in_ch.vertex_b) ? in_ch.vertex_a : in_ch.vertex_b;
    assign ab_mx = (in_ch.vertex_a > in_ch.vertex_b) ? in_ch.vertex_a : in_ch.vertex_b;
    assign in_mn = (in_ch.vertex_c < ab_mn) ? in_ch.vertex_c : ab_mn;
    assign in_mx = (in_ch.vertex_c > ab_mx) ? in_ch.vertex_c : ab_mx;
    assign key_raw = KEY_BITS'(in_mn) * KEY_BITS'(KEY_MUL_MIN)
                   + KEY_BITS'(in_mx) * KEY_BITS'(KEY_MUL_MAX);
    assign req_go = (in_ch.kind == KIND_INSERT || in_ch.kind == KIND_LOOKUP)
                    && (in_mn != '0);

    tfh_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (key_raw),
        .divisor   (bkt_eff),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    tfh_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd    = entry_t'(ram_rdata);
    assign hit   = rd.min_vertex == mn_reg && rd.max_vertex == mx_reg
                   && rd.vertex_sum == sum_reg;
    assign empty = first_reg && rd.min_vertex == '0;
    assign more  = rd.link != '0 && {1'b0, rd.link} < lim_eff;
    assign room  = nf_reg < lim_eff;
    assign store_home  = empty && kind_reg == KIND_INSERT;
    assign store_chain = !empty && !hit && !more && kind_reg == KIND_INSERT && room;

    always_comb
    begin
        new_entry.min_vertex = mn_reg;
        new_entry.max_vertex = mx_reg;
        new_entry.vertex_sum = sum_reg;
        new_entry.id         = id_reg;
        new_entry.link       = '0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
            begin
                if (clr_reg == ADDR_BITS'(TABLE_DEPTH - 1))
                    state_next = pend_reg ? S_DONE : S_IDLE;
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (in_ch.kind == KIND_CLEAR)
                        state_next = S_CLR;
                    else if (req_go)
                        state_next = S_MOD;
                    else
                        state_next = S_DONE;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                    state_next = S_RD;
            end
            S_RD:
                state_next = S_CHK;
            S_CHK:
            begin
                if (empty || hit)
                    state_next = S_DONE;
                else if (more)
                    state_next = S_RD;
                else if (store_chain)
                    state_next = S_NEW;
                else
                    state_next = S_DONE;
            end
            S_NEW:
                state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
        if (cfg_clr)
            state_next = S_CLR;
    end

    // outputs
    always_comb
    begin
        ram_we      = 1'b0;
        ram_addr    = cur_reg;
        ram_wdata   = new_entry;
        mod_start   = 1'b0;
        in_ch.ready = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
            end
            S_IDLE:
            begin
                in_ch.ready = !cfg.valid;
                mod_start   = req_fire && req_go;
            end
            S_CHK:
            begin
                if (store_home)
                begin
                    ram_we = 1'b1;
                end
                else if (store_chain)
                begin
                    ram_we         = 1'b1;
                    ram_wdata      = rd;
                    ram_wdata.link = nf_reg[ADDR_BITS-1:0];
                end
            end
            S_NEW:
            begin
                ram_we   = 1'b1;
                ram_addr = nf_reg[ADDR_BITS-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            first_reg     <= 1'b0;
            nf_reg        <= '0;
            out_valid_reg <= 1'b0;
            bucket_reg    <= BUCKET_RESET;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            if (cfg_clr)
            begin
                clr_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else
            begin
                unique case (state_reg)
                    S_CLR:
                    begin
                        clr_reg <= clr_reg + 1'b1;
                        if (clr_reg == ADDR_BITS'(TABLE_DEPTH - 1))
                        begin
                            nf_reg   <= bkt_eff;
                            pend_reg <= 1'b0;
                        end
                    end
                    S_IDLE:
                    begin
                        clr_reg   <= '0;
                        first_reg <= 1'b1;
                        if (req_fire)
                            pend_reg <= in_ch.kind == KIND_CLEAR;
                    end
                    S_CHK:
                        first_reg <= 1'b0;
                    S_NEW:
                        nf_reg <= nf_reg + 1'b1;
                    default:
                    begin
                    end
                endcase
            end
            if (cfg_fire)
            begin
                unique case (cfg.index)
                    CFG_BUCKET_COUNT: bucket_reg <= cfg.data[BKT_BITS-1:0];
                    CFG_TABLE_LIMIT:  limit_reg  <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_CLR:
            begin
                res_status_reg <= ST_CLEARED;
                res_id_reg     <= '0;
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    kind_reg       <= in_ch.kind;
                    mn_reg         <= in_mn;
                    mx_reg         <= in_mx;
                    sum_reg        <= SUM_BITS'(in_ch.vertex_a) + SUM_BITS'(in_ch.vertex_b)
                                      + SUM_BITS'(in_ch.vertex_c);
                    id_reg         <= in_ch.face_id;
                    res_status_reg <= ST_MISS;
                    res_id_reg     <= '0;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                    cur_reg <= mod_rem;
            end
            S_CHK:
            begin
                if (empty)
                    res_status_reg <= store_home ? ST_NEW : ST_MISS;
                else if (hit)
                begin
                    res_status_reg <= ST_FOUND;
                    res_id_reg     <= rd.id;
                end
                else if (more)
                    cur_reg <= rd.link;
                else if (kind_reg != KIND_INSERT)
                    res_status_reg <= ST_MISS;
                else
                    res_status_reg <= room ? ST_NEW : ST_FULL;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_status_reg <= res_status_reg;
                    out_id_reg     <= res_id_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.status   = out_status_reg;
    assign out_ch.match_id = out_id_reg;

`ifndef SYNTH
    a_nf_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLR && !$past(cfg_fire)) |-> nf_reg <= lim_eff)
        else $error("overflow pointer beyond table limit");

    a_id_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_FOUND) |-> out_id_reg == '0)
        else $error("match id set without a hit");

    a_clear_after_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && res_status_reg == ST_CLEARED)
        |-> ($past(state_reg) == S_CLR || $past(state_reg) == S_DONE))
        else $error("clear reported without a clearing pass");
`endif

endmodule

// ----- tb/tfh_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfh_checker
// Watches the request, result and register write channels of the triangle
// hash table, keeps its own copy of the table and registers, works out the
// status and id due for every accepted request and compares each result
// against the oldest one still owed.
// ----------------------------------------------------------------------------
module tfh_checker
    import tfh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tfh_req_if   req,
    tfh_res_if   res,
    tfh_cfg_if   cfg,
    output int   fail_count,
    output int   pending
);

    typedef struct {
        logic [STATUS_BITS-1:0] status;
        logic [ID_BITS-1:0]     id;
    } answer_t;

    answer_t answers_owed[$];

    logic [BKT_BITS-1:0]      bucket_reg;
    logic [CFG_DATA_BITS-1:0] limit_reg;

    logic [VERTEX_BITS-1:0] tri_min  [TABLE_DEPTH];
    logic [VERTEX_BITS-1:0] tri_max  [TABLE_DEPTH];
    logic [SUM_BITS-1:0]    tri_sum  [TABLE_DEPTH];
    logic [ID_BITS-1:0]     tri_id   [TABLE_DEPTH];
    int                     tri_link [TABLE_DEPTH];
    int                     free_slot;

    function automatic int usable_entries();
        int l;
        l = limit_reg;
        if (l < 1) l = 1;
        if (l > TABLE_DEPTH) l = TABLE_DEPTH;
        return l;
    endfunction

    function automatic int home_buckets();
        int b;
        int l;
        b = bucket_reg;
        l = usable_entries();
        if (b < 1) b = 1;
        if (b > l) b = l;
        return b;
    endfunction

    function automatic void empty_table();
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            tri_min[i]  = '0;
            tri_max[i]  = '0;
            tri_sum[i]  = '0;
            tri_id[i]   = '0;
            tri_link[i] = 0;
        end
        free_slot = home_buckets();
    endfunction

    function automatic void store_triangle(int e, logic [VERTEX_BITS-1:0] mn,
                                           logic [VERTEX_BITS-1:0] mx,
                                           logic [SUM_BITS-1:0] s,
                                           logic [ID_BITS-1:0] id);
        tri_min[e]  = mn;
        tri_max[e]  = mx;
        tri_sum[e]  = s;
        tri_id[e]   = id;
        tri_link[e] = 0;
    endfunction

    function automatic answer_t resolve_request(logic [KIND_BITS-1:0] kind,
                                                logic [VERTEX_BITS-1:0] a,
                                                logic [VERTEX_BITS-1:0] b,
                                                logic [VERTEX_BITS-1:0] c,
                                                logic [ID_BITS-1:0] id);
        answer_t                o;
        logic [VERTEX_BITS-1:0] mn;
        logic [VERTEX_BITS-1:0] mx;
        logic [SUM_BITS-1:0]    s;
        longint                 key;
        int                     e;
        int                     nxt;
        int                     lim;
        o.status = ST_MISS;
        o.id     = '0;
        if (kind == KIND_CLEAR)
        begin
            empty_table();
            o.status = ST_CLEARED;
            return o;
        end
        if (kind != KIND_INSERT && kind != KIND_LOOKUP)
            return o;
        mn = (a < b) ? a : b;
        if (c < mn) mn = c;
        mx = (a > b) ? a : b;
        if (c > mx) mx = c;
        if (mn == 0)
            return o;
        s   = SUM_BITS'(a) + SUM_BITS'(b) + SUM_BITS'(c);
        key = (KEY_MUL_MIN * longint'(mn) + KEY_MUL_MAX * longint'(mx))
              % home_buckets();
        lim = usable_entries();
        if (tri_min[key] == 0)
        begin
            if (kind == KIND_INSERT)
            begin
                store_triangle(int'(key), mn, mx, s, id);
                o.status = ST_NEW;
            end
            return o;
        end
        e = int'(key);
        for (int steps = 0; steps < TABLE_DEPTH; steps++)
        begin
            if (tri_min[e] == mn && tri_max[e] == mx && tri_sum[e] == s)
            begin
                o.status = ST_FOUND;
                o.id     = tri_id[e];
                return o;
            end
            nxt = tri_link[e];
            if (nxt == 0 || nxt >= lim) break;
            e = nxt;
        end
        if (kind == KIND_LOOKUP)
            return o;
        if (free_slot >= lim)
        begin
            o.status = ST_FULL;
            return o;
        end
        tri_link[e] = free_slot;
        store_triangle(free_slot, mn, mx, s, id);
        free_slot++;
        o.status = ST_NEW;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            bucket_reg = BUCKET_RESET;
            limit_reg  = CFG_DATA_BITS'(TABLE_DEPTH);
            empty_table();
            answers_owed.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_BUCKET_COUNT)
                begin
                    bucket_reg = cfg.data[BKT_BITS-1:0];
                    empty_table();
                end
                else if (cfg.index == CFG_TABLE_LIMIT)
                begin
                    limit_reg = cfg.data;
                    empty_table();
                end
            end
            if (req.valid && req.ready)
                answers_owed.push_back(resolve_request(req.kind, req.vertex_a,
                                                       req.vertex_b, req.vertex_c,
                                                       req.face_id));
            if (res.valid && res.ready)
            begin
                if (answers_owed.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result status=%0d id=%0h",
                             $time, res.status, res.match_id);
                end
                else
                begin
                    want = answers_owed.pop_front();
                    if (res.status !== want.status)
                    begin
                        fail_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, res.status);
                    end
                    if (res.match_id !== want.id)
                    begin
                        fail_count++;
                        $display("%0t: match_id expected %0h actual %0h",
                                 $time, want.id, res.match_id);
                    end
                end
            end
        end
        pending = answers_owed.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the triangle hash table: a directed opening on the reset
// settings, then phases of register settings each followed by random inserts,
// lookups, clears, spare-kind and zero-vertex requests drawn mostly from a small
// set of triangles in shuffled vertex order, with random request gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import tfh_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int POOL_SIZE   = 40;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_REQS  = 200;

    localparam logic [KIND_BITS-1:0]    KIND_SPARE  = 2'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic quiet = 1'b0;
    int   cycles = 0;
    int   sent = 0;
    int   taken = 0;
    int   fail_count;
    int   pending;

    tfh_req_if req_ch ();
    tfh_res_if res_ch ();
    tfh_cfg_if cfg_ch ();

    triangle_face_hash_table dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (req_ch),
        .out_ch (res_ch),
        .cfg    (cfg_ch)
    );

    tfh_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .res        (res_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    logic [VERTEX_BITS-1:0] pool_a [POOL_SIZE];
    logic [VERTEX_BITS-1:0] pool_b [POOL_SIZE];
    logic [VERTEX_BITS-1:0] pool_c [POOL_SIZE];

    int bucket_vals [NUM_PHASES] = '{1, 4095, 7, 0, 3, 2, 50, 1024};
    int limit_vals  [NUM_PHASES] = '{16, 4096, 64, 0, 8191, 2, 60, 4096};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (req_ch.valid && req_ch.ready) sent++;
        if (res_ch.valid && res_ch.ready) taken++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int gap;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = quiet ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                res_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ch.ready = 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    task automatic send_request(logic [KIND_BITS-1:0] kind,
                                logic [VERTEX_BITS-1:0] a,
                                logic [VERTEX_BITS-1:0] b,
                                logic [VERTEX_BITS-1:0] c);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid    = 1'b1;
        req_ch.kind     = kind;
        req_ch.vertex_a = a;
        req_ch.vertex_b = b;
        req_ch.vertex_c = c;
        req_ch.face_id  = ID_BITS'($urandom);
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_BITS-1:0] index, int value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = index;
        cfg_ch.data  = CFG_DATA_BITS'(value);
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic drain();
        req_ch.valid = 1'b0;
        while (taken != sent) @(negedge clk);
    endtask

    // one pool triangle, vertices in a random order
    task automatic send_pooled(logic [KIND_BITS-1:0] kind);
        int p;
        logic [VERTEX_BITS-1:0] v [3];
        logic [VERTEX_BITS-1:0] t;
        int j;
        p = $urandom_range(0, POOL_SIZE - 1);
        v[0] = pool_a[p];
        v[1] = pool_b[p];
        v[2] = pool_c[p];
        for (int i = 2; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = v[i];
            v[i] = v[j];
            v[j] = t;
        end
        send_request(kind, v[0], v[1], v[2]);
    endtask

    function automatic logic [VERTEX_BITS-1:0] pick_vertex();
        if ($urandom_range(0, 3) == 0)
            return VERTEX_BITS'($urandom) | VERTEX_BITS'(1);
        return VERTEX_BITS'($urandom_range(1, 60));
    endfunction

    initial
    begin
        int r;
        logic [VERTEX_BITS-1:0] zv [3];
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_INSERT;
        req_ch.vertex_a = '0;
        req_ch.vertex_b = '0;
        req_ch.vertex_c = '0;
        req_ch.face_id = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_BUCKET_COUNT;
        cfg_ch.data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        quiet = 1'b1;
        send_request(KIND_INSERT, 24'd1, 24'd2, 24'd3);
        send_request(KIND_INSERT, 24'd3, 24'd1, 24'd2);
        send_request(KIND_LOOKUP, 24'd2, 24'd3, 24'd1);
        send_request(KIND_LOOKUP, 24'd1, 24'd2, 24'd4);
        send_request(KIND_INSERT, 24'd1, 24'd5, 24'd10);
        send_request(KIND_INSERT, 24'd1, 24'd6, 24'd10);
        send_request(KIND_LOOKUP, 24'd10, 24'd6, 24'd1);
        send_request(KIND_LOOKUP, 24'd1, 24'd7, 24'd10);
        send_request(KIND_INSERT, 24'd0, 24'd5, 24'd9);
        send_request(KIND_LOOKUP, 24'd4, 24'd0, 24'd9);
        send_request(KIND_SPARE, '1, '1, '1);
        send_request(KIND_INSERT, '1, '1, '1);
        send_request(KIND_LOOKUP, '1, '1, '1);
        send_request(KIND_INSERT, 24'd1, '1, 24'h800000);
        send_request(KIND_LOOKUP, 24'h800000, 24'd1, '1);
        send_request(KIND_CLEAR, '1, '1, '1);
        send_request(KIND_LOOKUP, 24'd1, 24'd2, 24'd3);
        send_request(KIND_INSERT, 24'd3, 24'd2, 24'd1);
        send_request(KIND_LOOKUP, 24'd1, 24'd3, 24'd2);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            quiet = (ph % 3 == 2);
            write_register(CFG_BUCKET_COUNT, bucket_vals[ph]);
            write_register(CFG_TABLE_LIMIT, limit_vals[ph]);
            write_register(CFG_SPARE_A, $urandom_range(0, 8191));
            write_register(CFG_SPARE_B, $urandom_range(0, 8191));
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                pool_a[i] = pick_vertex();
                pool_b[i] = pick_vertex();
                pool_c[i] = pick_vertex();
            end
            for (int n = 0; n < PHASE_REQS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    send_pooled(KIND_INSERT);
                else if (r < 75)
                    send_pooled(KIND_LOOKUP);
                else if (r < 86)
                    send_request(KIND_INSERT, VERTEX_BITS'($urandom),
                                 VERTEX_BITS'($urandom), VERTEX_BITS'($urandom));
                else if (r < 91)
                    send_request(KIND_LOOKUP, VERTEX_BITS'($urandom),
                                 VERTEX_BITS'($urandom), VERTEX_BITS'($urandom));
                else if (r < 95)
                begin
                    zv[0] = VERTEX_BITS'($urandom);
                    zv[1] = VERTEX_BITS'($urandom);
                    zv[2] = VERTEX_BITS'($urandom);
                    zv[$urandom_range(0, 2)] = '0;
                    send_request(KIND_BITS'($urandom_range(0, 1)), zv[0], zv[1], zv[2]);
                end
                else if (r < 97)
                    send_request(KIND_SPARE, VERTEX_BITS'($urandom),
                                 VERTEX_BITS'($urandom), VERTEX_BITS'($urandom));
                else if (r < 98)
                    send_request(KIND_CLEAR, VERTEX_BITS'($urandom),
                                 VERTEX_BITS'($urandom), VERTEX_BITS'($urandom));
                else
                    send_request(KIND_INSERT, '1,
                                 VERTEX_BITS'($urandom) | VERTEX_BITS'(1), '1);
            end
            drain();
        end

        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
